>>> rtl/core/tcgr_pkg.sv
// shared types and constants for the text console glyph renderer
package tcgr_pkg;

  localparam int DEF_COLUMNS     = 60;
  localparam int DEF_ROWS        = 26;
  localparam int DEF_GLYPH_COUNT = 96;
  localparam int GLYPH_HEIGHT    = 6;
  localparam int LINE_WORDS      = 60;
  localparam int ROW_STRIDE      = GLYPH_HEIGHT * LINE_WORDS;
  localparam int QUEUE_DEPTH     = 4;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 208;
  localparam int ADDR_W     = 14;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_LOAD,
    OP_SET
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [6:0]  glyph;
    logic [2:0]  glyph_row;
    logic [31:0] word;
    logic [5:0]  col;
    logic [4:0]  row;
  } op_t;

  typedef struct packed {
    logic [5:0] col;
    logic [4:0] row;
  } cursor_status_t;

endpackage

>>> rtl/core/tcgr_front.sv
// input side: accepts words and classifies them into queued operations
module tcgr_front #(
  parameter int COLUMNS     = tcgr_pkg::DEF_COLUMNS,
  parameter int ROWS        = tcgr_pkg::DEF_ROWS,
  parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // char_code, new_col, new_row, glyph_index, glyph_row, glyph_word, zero pad
  input  logic [tcgr_pkg::IN_DATA_W-1:0] s_tdata,
  // command
  input  logic [tcgr_pkg::IN_USER_W-1:0] s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output tcgr_pkg::op_t                  q_op
);
  import tcgr_pkg::*;

  logic [7:0]  char_code;
  logic [5:0]  new_col;
  logic [4:0]  new_row;
  logic [6:0]  glyph_index;
  logic [2:0]  glyph_row;
  logic [31:0] glyph_word;
  logic [6:0]  c7;
  logic [6:0]  glyph;

  assign char_code   = s_tdata[7:0];
  assign new_col     = s_tdata[13:8];
  assign new_row     = s_tdata[18:14];
  assign glyph_index = s_tdata[25:19];
  assign glyph_row   = s_tdata[28:26];
  assign glyph_word  = s_tdata[60:29];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  assign c7 = char_code[6:0];

  always_comb begin
    if (c7 >= 7'h20) begin
      glyph = c7 - 7'h20;
    end else begin
      glyph = 7'd0;
    end
    if (int'(glyph) >= GLYPH_COUNT) begin
      glyph = 7'd0;
    end
  end

  always_comb begin
    q_op.kind      = OP_NOP;
    q_op.glyph     = glyph;
    q_op.glyph_row = glyph_row;
    q_op.word      = glyph_word;
    q_op.col       = (int'(new_col) < COLUMNS) ? new_col : 6'(COLUMNS - 1);
    q_op.row       = (int'(new_row) < ROWS) ? new_row : 5'(ROWS - 1);
    case (s_tuser)
      CMD_PUT: begin
        if (char_code == CHAR_LF) begin
          q_op.kind = OP_LF;
        end else if (char_code == CHAR_CR) begin
          q_op.kind = OP_CR;
        end else begin
          q_op.kind = OP_PUT;
        end
      end
      CMD_LOAD: begin
        if (int'(glyph_index) < GLYPH_COUNT && int'(glyph_row) < GLYPH_HEIGHT) begin
          q_op.kind  = OP_LOAD;
          q_op.glyph = glyph_index;
        end
      end
      CMD_SET: begin
        q_op.kind = OP_SET;
      end
      default: begin
        q_op.kind = OP_NOP;
      end
    endcase
  end

endmodule

>>> rtl/core/tcgr_queue.sv
// short operation queue between front and back
module tcgr_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  tcgr_pkg::op_t                          push_op,
  output logic                                   full,
  input  logic                                   pop,
  output logic                                   not_empty,
  output tcgr_pkg::op_t                          head,
  output logic [$clog2(tcgr_pkg::QUEUE_DEPTH):0] count
);
  import tcgr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign full      = (int'(count) == QUEUE_DEPTH);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tcgr_back.sv
// back end: cursor, font memory and the cell write sequencer
module tcgr_back #(
  parameter int COLUMNS     = tcgr_pkg::DEF_COLUMNS,
  parameter int ROWS        = tcgr_pkg::DEF_ROWS,
  parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      text_attr,
  input  logic                            q_not_empty,
  input  tcgr_pkg::op_t                   q_head,
  output logic                            q_pop,
  output tcgr_pkg::cursor_status_t        status,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // word_address, row0_pixels .. row5_pixels, zero pad
  output logic [tcgr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import tcgr_pkg::*;

  localparam int GW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PUT   = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t                          state;
  logic [5:0]                      cursor_col;
  logic [4:0]                      cursor_row;
  logic [5:0]                      clear_col;
  logic [GLYPH_HEIGHT-1:0][31:0]   font [GLYPH_COUNT];
  logic [GLYPH_HEIGHT-1:0][31:0]   rdata;
  logic                            rd_en;
  logic [GW-1:0]                   rd_addr;
  logic                            out_free;
  logic [4:0]                      row_inc;
  logic                            col_wrap;
  logic [31:0]                     fg;
  logic [31:0]                     bg;
  logic [5:0]                      emit_col;
  logic [ADDR_W-1:0]               emit_addr;
  logic [GLYPH_HEIGHT*32-1:0]      pixels;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = (state == S_IDLE) && q_not_empty;
  assign row_inc  = (int'(cursor_row) == ROWS - 1) ? 5'd0 : cursor_row + 1'b1;
  assign col_wrap = (int'(cursor_col) == COLUMNS - 1);

  assign status.col = cursor_col;
  assign status.row = cursor_row;

  assign fg = {4{4'h0, text_attr[3:0]}};
  assign bg = {4{4'h0, text_attr[7:4]}};

  assign emit_col  = (state == S_CLEAR) ? clear_col : cursor_col;
  assign emit_addr = ADDR_W'(int'(cursor_row) * ROW_STRIDE + int'(emit_col));

  always_comb begin
    for (int k = 0; k < GLYPH_HEIGHT; k++) begin
      pixels[k*32 +: 32] = (fg & rdata[k]) | (bg & ~rdata[k]);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (q_pop && q_head.kind == OP_PUT) begin
      rd_en   = 1'b1;
      rd_addr = q_head.glyph[GW-1:0];
    end else if (q_pop && q_head.kind == OP_LF) begin
      rd_en = 1'b1;
    end else if (state == S_PUT && out_free && col_wrap) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == OP_LOAD) begin
      font[q_head.glyph[GW-1:0]][q_head.glyph_row] <= q_head.word;
    end
    if (rd_en) begin
      rdata <= font[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUT || state == S_CLEAR) && out_free) begin
      m_tdata <= {{(OUT_DATA_W - ADDR_W - GLYPH_HEIGHT * 32){1'b0}}, pixels, emit_addr};
      if (state == S_PUT) begin
        m_tlast <= !col_wrap;
      end else begin
        m_tlast <= (int'(clear_col) == COLUMNS - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      clear_col  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if ((state == S_PUT || state == S_CLEAR) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_head.kind)
              OP_PUT: begin
                state <= S_PUT;
              end
              OP_LF: begin
                cursor_col <= '0;
                cursor_row <= row_inc;
                clear_col  <= '0;
                state      <= S_CLEAR;
              end
              OP_CR: begin
                cursor_col <= '0;
              end
              OP_SET: begin
                cursor_col <= q_head.col;
                cursor_row <= q_head.row;
              end
              default: begin
              end
            endcase
          end
        end
        S_PUT: begin
          if (out_free) begin
            if (col_wrap) begin
              cursor_col <= '0;
              cursor_row <= row_inc;
              clear_col  <= '0;
              state      <= S_CLEAR;
            end else begin
              cursor_col <= cursor_col + 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        S_CLEAR: begin
          if (out_free) begin
            clear_col <= clear_col + 1'b1;
            if (int'(clear_col) == COLUMNS - 1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/text_console_glyph_renderer.sv
// top level of the text console glyph renderer
// a printed character goes through the queue, the font read register and the output register
// font load, set cursor and carriage return act as the back end takes them from the queue
// a character emits its cell, and also clears the next line when it wraps the line
// line feed clears the next line; the sequencer emits one cell per cycle while output is free
// reset clears cursor, attribute, queue and sequencer; font memory holds garbage until loaded
module text_console_glyph_renderer #(
  parameter int COLUMNS     = tcgr_pkg::DEF_COLUMNS,
  parameter int ROWS        = tcgr_pkg::DEF_ROWS,
  parameter int GLYPH_COUNT = tcgr_pkg::DEF_GLYPH_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  // text_attr
  input  logic [7:0]                      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // char_code, new_col, new_row, glyph_index, glyph_row, glyph_word, zero pad
  input  logic [tcgr_pkg::IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [tcgr_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // word_address, row0_pixels .. row5_pixels, zero pad
  output logic [tcgr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import tcgr_pkg::*;

  logic                           text_attr_unused_guard;
  logic [7:0]                     text_attr;
  logic                           q_full;
  logic                           q_push;
  op_t                            q_in;
  logic                           q_pop;
  logic                           q_not_empty;
  op_t                            q_head;
  logic [$clog2(QUEUE_DEPTH):0]   q_count;
  cursor_status_t                 status;

  assign cfg_ready              = 1'b1;
  assign text_attr_unused_guard = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= '0;
    end else if (text_attr_unused_guard) begin
      text_attr <= cfg_data;
    end
  end

  tcgr_front #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_in)
  );

  tcgr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  tcgr_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .text_attr   (text_attr),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .status      (status),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    int'(status.col) < COLUMNS && int'(status.row) < ROWS)
    else $error("cursor out of range");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> int'(m_tdata[ADDR_W-1:0]) < ROWS * ROW_STRIDE)
    else $error("cell address beyond screen");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    int'(q_count) <= QUEUE_DEPTH && !(q_pop && !q_not_empty))
    else $error("queue overflow or underflow");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !s_tready && !q_push)
    else $error("push into full queue");
`endif

endmodule

>>> bench/tb_top.sv
// self-checking bench for the text console glyph renderer with its own cell predictor
module tb_top;
  import tcgr_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int GLYPH_COUNT = DEF_GLYPH_COUNT;
  localparam int FONT_WORDS  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam logic [1:0] CMD_IDLE = 2'd3;

  typedef struct {
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [5:0]  new_col;
    logic [4:0]  new_row;
    logic [6:0]  glyph_index;
    logic [2:0]  glyph_row;
    logic [31:0] glyph_word;
  } console_word_t;

  typedef struct {
    logic [ADDR_W-1:0] word_address;
    logic [31:0]       pixels [GLYPH_HEIGHT];
    logic              is_last;
  } cell_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;

  text_console_glyph_renderer uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // predictor state
  logic [5:0]  cur_col = '0;
  logic [4:0]  cur_row = '0;
  logic [7:0]  attr_reg = 8'h00;
  logic [31:0] font_mem [FONT_WORDS];

  // stimulus bookkeeping
  console_word_t console_words [$];
  cell_word_t    cells_due [$];
  console_word_t cur_word;
  logic [5:0]    font_loaded [GLYPH_COUNT];
  int            ready_glyphs [$];
  int            words_queued = 0;
  int            words_taken = 0;
  int            phase_words = 0;
  int            cells_seen = 0;
  int            hold_left = 0;
  int            errors = 0;
  logic          calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic render_cell(input logic [6:0] glyph, input logic [5:0] col,
                             input logic [4:0] row, input logic is_last);
    cell_word_t c;
    logic [31:0] fg;
    logic [31:0] bg;
    logic [31:0] mask;
    fg = {4{4'h0, attr_reg[3:0]}};
    bg = {4{4'h0, attr_reg[7:4]}};
    if (glyph >= GLYPH_COUNT) glyph = '0;
    c.word_address = ADDR_W'(row * ROW_STRIDE + col);
    for (int k = 0; k < GLYPH_HEIGHT; k++) begin
      mask = font_mem[glyph * GLYPH_HEIGHT + k];
      c.pixels[k] = (fg & mask) | (bg & ~mask);
    end
    c.is_last = is_last;
    cells_due.push_back(c);
  endtask

  task automatic clear_next_line();
    cur_col = '0;
    cur_row = (cur_row >= ROWS - 1) ? '0 : cur_row + 5'd1;
    for (int x = 0; x < COLUMNS; x++)
      render_cell('0, 6'(x), cur_row, x == COLUMNS - 1);
  endtask

  task automatic console_step(input console_word_t w);
    logic [6:0] c7;
    logic       wraps;
    case (w.command)
      CMD_LOAD: begin
        if (w.glyph_index < GLYPH_COUNT && w.glyph_row < GLYPH_HEIGHT)
          font_mem[w.glyph_index * GLYPH_HEIGHT + w.glyph_row] = w.glyph_word;
      end
      CMD_SET: begin
        cur_col = (w.new_col < COLUMNS) ? w.new_col : 6'(COLUMNS - 1);
        cur_row = (w.new_row < ROWS) ? w.new_row : 5'(ROWS - 1);
      end
      CMD_PUT: begin
        if (w.char_code == CHAR_LF) begin
          clear_next_line();
        end else if (w.char_code == CHAR_CR) begin
          cur_col = '0;
        end else begin
          c7 = w.char_code[6:0];
          wraps = (cur_col >= COLUMNS - 1);
          render_cell((c7 >= 7'h20) ? c7 - 7'h20 : 7'h00, cur_col, cur_row, !wraps);
          cur_col = cur_col + 6'd1;
          if (wraps) clear_next_line();
        end
      end
      default: ;
    endcase
  endtask

  // driver: input words go out in order, with random gaps except in the calm phase
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        console_step(cur_word);
        words_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (console_words.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
          cur_word = console_words.pop_front();
          s_tdata <= {3'b000, cur_word.glyph_word, cur_word.glyph_row, cur_word.glyph_index,
                      cur_word.new_row, cur_word.new_col, cur_word.char_code};
          s_tuser <= cur_word.command;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: every cell word is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cells_due.size() == 0) begin
          $error("unexpected cell word at address %0d", m_tdata[ADDR_W-1:0]);
          errors++;
        end else begin
          cell_word_t c;
          c = cells_due.pop_front();
          if (m_tdata[ADDR_W-1:0] !== c.word_address) begin
            $error("word_address: expected %0d, got %0d", c.word_address,
                   m_tdata[ADDR_W-1:0]);
            errors++;
          end
          for (int k = 0; k < GLYPH_HEIGHT; k++) begin
            if (m_tdata[ADDR_W + 32*k +: 32] !== c.pixels[k]) begin
              $error("row%0d_pixels: expected %h, got %h", k, c.pixels[k],
                     m_tdata[ADDR_W + 32*k +: 32]);
              errors++;
            end
          end
          if (m_tlast !== c.is_last) begin
            $error("last: expected %0d, got %0d", c.is_last, m_tlast);
            errors++;
          end
        end
        cells_seen++;
        // long back-pressure so the input side fills and stalls
        if (cells_seen == 150 || cells_seen == 1000) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || $urandom_range(99) >= 10;
      end
    end
  end

  function automatic console_word_t random_word();
    console_word_t w;
    w.command     = 2'($urandom_range(3));
    w.char_code   = 8'($urandom);
    w.new_col     = 6'($urandom);
    w.new_row     = 5'($urandom);
    w.glyph_index = 7'($urandom);
    w.glyph_row   = 3'($urandom);
    w.glyph_word  = $urandom;
    return w;
  endfunction

  task automatic queue_word(input console_word_t w);
    console_words.push_back(w);
    words_queued++;
    phase_words++;
  endtask

  task automatic queue_load(input int glyph, input int row, input logic [31:0] mask);
    console_word_t w;
    w = random_word();
    w.command = CMD_LOAD;
    w.glyph_index = 7'(glyph);
    w.glyph_row = 3'(row);
    w.glyph_word = mask;
    if (glyph < GLYPH_COUNT && row < GLYPH_HEIGHT) begin
      if (font_loaded[glyph] != 6'h3F) begin
        font_loaded[glyph][row] = 1'b1;
        if (font_loaded[glyph] == 6'h3F) ready_glyphs.push_back(glyph);
      end
    end
    queue_word(w);
  endtask

  // a character other than LF or CR is only sent once every row of its glyph has been loaded
  task automatic queue_put(input logic [7:0] code);
    console_word_t w;
    int glyph;
    glyph = (code[6:0] >= 7'h20) ? code[6:0] - 7'h20 : 0;
    if (glyph >= GLYPH_COUNT) glyph = 0;
    if (code != CHAR_LF && code != CHAR_CR) begin
      for (int k = 0; k < GLYPH_HEIGHT; k++)
        if (!font_loaded[glyph][k]) queue_load(glyph, k, $urandom);
    end
    w = random_word();
    w.command = CMD_PUT;
    w.char_code = code;
    queue_word(w);
  endtask

  task automatic queue_cursor(input logic [5:0] col, input logic [4:0] row);
    console_word_t w;
    w = random_word();
    w.command = CMD_SET;
    w.new_col = col;
    w.new_row = row;
    queue_word(w);
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || cells_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    attr_reg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_words();
    console_word_t w;
    logic [31:0] masks [GLYPH_HEIGHT];
    masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h00FF_00FF,
              32'hA5A5_5A5A, 32'h8000_0001};
    for (int k = 0; k < GLYPH_HEIGHT; k++) queue_load(0, k, masks[k]);
    for (int k = 0; k < GLYPH_HEIGHT; k++) queue_load(GLYPH_COUNT - 1, k, ~masks[k]);
    // loads outside the font are dropped
    queue_load(127, 0, 32'hFFFF_FFFF);
    queue_load(5, 7, 32'hFFFF_FFFF);
    queue_load(GLYPH_COUNT, GLYPH_HEIGHT, 32'h1234_5678);
    // cursor saturates, then the last cell wraps to row 0 and clears it
    queue_cursor(6'h3F, 5'h1F);
    queue_put(8'hFF);
    queue_put(8'h00);
    queue_put(8'h8A);
    queue_put(CHAR_LF);
    queue_put(CHAR_CR);
    w = random_word();
    w.command = CMD_IDLE;
    queue_word(w);
    queue_cursor(6'd0, 5'd0);
    queue_put(8'h7F);
  endtask

  task automatic random_phase(input int count);
    console_word_t w;
    int pick;
    int glyph;
    phase_words = 0;
    while (phase_words < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(3) != 0) begin
          glyph = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
          queue_put(8'(glyph + 8'h20) | 8'($urandom_range(1) << 7));
        end else begin
          queue_put(8'($urandom_range(255)));
        end
      end else if (pick < 55) begin
        queue_put(CHAR_LF);
      end else if (pick < 60) begin
        queue_put(CHAR_CR);
      end else if (pick < 72) begin
        queue_cursor($urandom_range(1) ? 6'($urandom_range(54, 63)) : 6'($urandom),
                     5'($urandom));
      end else if (pick < 87) begin
        queue_load($urandom_range(GLYPH_COUNT - 1), $urandom_range(GLYPH_HEIGHT - 1),
                   $urandom);
      end else if (pick < 93) begin
        if ($urandom_range(1)) queue_load($urandom_range(GLYPH_COUNT, 127),
                                          $urandom_range(7), $urandom);
        else queue_load($urandom_range(GLYPH_COUNT - 1),
                        $urandom_range(GLYPH_HEIGHT, 7), $urandom);
      end else begin
        w = random_word();
        w.command = CMD_IDLE;
        queue_word(w);
      end
    end
  endtask

  initial begin
    logic [7:0] attrs [6];
    for (int g = 0; g < GLYPH_COUNT; g++) font_loaded[g] = '0;
    attrs = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'($urandom), 8'($urandom)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_attr(8'h3C);
    directed_words();
    wait_idle();
    for (int p = 0; p < 6; p++) begin
      write_attr(attrs[p]);
      calm <= (p == 2);
      random_phase(32);
      wait_idle();
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && cells_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> text_console_glyph_renderer.f
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_front.sv
rtl/core/tcgr_queue.sv
rtl/core/tcgr_back.sv
rtl/core/text_console_glyph_renderer.sv
bench/tb_top.sv
